[rtl/rotation_matrix_to_quaternion_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// ---------------------------------------------------------------------------
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// implication checked on every clock, off during reset
`define RMQ_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define RMQ_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/rmq_pkg.sv]
// ---------------------------------------------------------------------------
// rmq_pkg
// Shared types and constants for the matrix-to-quaternion pipeline.
// ---------------------------------------------------------------------------
`default_nettype none
package rmq_pkg;
  localparam int FracBits = 14;
  localparam int RootInW  = 34;
  localparam int RootW    = RootInW / 2;
  localparam int DenW     = RootW + 2;
  localparam int PairW    = 17;
  localparam int NumW     = PairW - 1 + FracBits + 1;
  localparam int QuoW     = NumW;
  localparam logic [1:0] PivX = 2'd0;
  localparam logic [1:0] PivY = 2'd1;
  localparam logic [1:0] PivZ = 2'd2;
  localparam logic [1:0] PivW = 2'd3;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } mat_t;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
    logic [1:0]         pivot;
    logic               invalid;
  } quat_t;

  typedef struct packed {
    logic [1:0]              pivot;
    logic                    bad;
    logic                    [2:0] neg;
    logic [3*PairW-1:0]      mag;
  } side_t;
endpackage
`default_nettype wire

[rtl/rmq_sqrt.sv]
// ---------------------------------------------------------------------------
// rmq_sqrt
// Pipelined restoring integer square root, one result bit per stage.
// ---------------------------------------------------------------------------
`default_nettype none
module rmq_sqrt
  import rmq_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               adv,
  input  wire logic [RootInW-1:0] radicand,
  output logic      [RootW-1:0]   root
);
  logic [RootInW-1:0] rem  [RootW+1];
  logic [RootW-1:0]   res  [RootW+1];
  logic [RootInW-1:0] rem_next [RootW];
  logic [RootW-1:0]   res_next [RootW];

  assign rem[0] = radicand;
  assign res[0] = '0;

  for (genvar i = 0; i < RootW; i++) begin : g_stage
    localparam int Sh = 2 * (RootW - 1 - i);
    logic [RootInW+1:0] trial;
    always_comb begin
      trial = ({2'b0, res[i]} << (RootW - i)) | ({{(RootInW+1){1'b0}}, 1'b1} << Sh);
      if ({2'b0, rem[i]} >= trial) begin
        rem_next[i] = rem[i] - trial[RootInW-1:0];
        res_next[i] = res[i] | (RootW'(1) << (RootW - 1 - i));
      end else begin
        rem_next[i] = rem[i];
        res_next[i] = res[i];
      end
    end
    if (i % 3 == 2) begin : g_reg
      always_ff @(posedge clk) begin
        if (adv) begin
          rem[i+1] <= rem_next[i];
          res[i+1] <= res_next[i];
        end
      end
    end else begin : g_pass
      assign rem[i+1] = rem_next[i];
      assign res[i+1] = res_next[i];
    end
  end

  assign root = res[RootW];
endmodule
`default_nettype wire

[rtl/rmq_div.sv]
// ---------------------------------------------------------------------------
// rmq_div
// Pipelined restoring unsigned divider with round-half-up quotient.
// ---------------------------------------------------------------------------
`default_nettype none
module rmq_div
  import rmq_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            adv,
  input  wire logic [NumW-1:0] num,
  input  wire logic [DenW-1:0] den,
  output logic      [QuoW-1:0] quo
);
  localparam int RemW = DenW + 1;
  logic [NumW-1:0] nm  [QuoW+1];
  logic [DenW-1:0] dv  [QuoW+1];
  logic [RemW-1:0] rm  [QuoW+1];
  logic [QuoW-1:0] qq  [QuoW+1];
  logic [NumW-1:0] nm_n [QuoW];
  logic [DenW-1:0] dv_n [QuoW];
  logic [RemW-1:0] rm_n [QuoW];
  logic [QuoW-1:0] qq_n [QuoW];

  assign nm[0] = num + NumW'(den >> 1);
  assign dv[0] = den;
  assign rm[0] = '0;
  assign qq[0] = '0;

  for (genvar i = 0; i < QuoW; i++) begin : g_stage
    logic [RemW:0] sh;
    always_comb begin
      sh = {rm[i], nm[i][NumW-1-i]};
      nm_n[i] = nm[i];
      dv_n[i] = dv[i];
      if (sh >= {2'b0, dv[i]}) begin
        rm_n[i] = RemW'(sh - {2'b0, dv[i]});
        qq_n[i] = qq[i] | (QuoW'(1) << (QuoW - 1 - i));
      end else begin
        rm_n[i] = sh[RemW-1:0];
        qq_n[i] = qq[i];
      end
    end
    if (i % 4 == 3) begin : g_reg
      always_ff @(posedge clk) begin
        if (adv) begin
          nm[i+1] <= nm_n[i];
          dv[i+1] <= dv_n[i];
          rm[i+1] <= rm_n[i];
          qq[i+1] <= qq_n[i];
        end
      end
    end else begin : g_pass
      assign nm[i+1] = nm_n[i];
      assign dv[i+1] = dv_n[i];
      assign rm[i+1] = rm_n[i];
      assign qq[i+1] = qq_n[i];
    end
  end

  assign quo = qq[QuoW];
endmodule
`default_nettype wire

[rtl/rotation_matrix_to_quaternion.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion
// Shepperd matrix-to-quaternion conversion, fully pipelined.
// ---------------------------------------------------------------------------
// Accepts one matrix request per cycle while in_stall is low and returns one
// quaternion per request in order. A request passes through the pivot
// register, the root stages (one register per three root bits), the divider
// stages (one register per four quotient bits) and the output register: one
// pivot register, five root registers, seven divider registers and the output
// register. The whole pipe advances only when the output register is free or
// being taken, so throughput is one item per cycle while the output is not stalled.
`default_nettype none
module rotation_matrix_to_quaternion
  import rmq_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  input  wire mat_t  in_data,
  output logic       out_valid,
  input  wire logic  out_stall,
  output quat_t      out_data
);
  localparam int SqLat  = RootW / 3;
  localparam int DivLat = QuoW / 4;
  localparam int Lat    = 1 + SqLat + DivLat;

  logic adv;
  logic [Lat-1:0] vld;
  side_t side [Lat];
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // stage 0: candidates, pivot, pair magnitudes
  logic signed [17:0] c0, c1, c2, c3, d;
  logic [1:0] pv;
  logic signed [16:0] p [3];
  logic signed [18:0] r;
  side_t s0;
  logic [RootInW-1:0] rad0;
  always_comb begin
    c0 = 18'(in_data.m00) - 18'(in_data.m11) - 18'(in_data.m22);
    c1 = 18'(in_data.m11) - 18'(in_data.m00) - 18'(in_data.m22);
    c2 = 18'(in_data.m22) - 18'(in_data.m00) - 18'(in_data.m11);
    c3 = 18'(in_data.m00) + 18'(in_data.m11) + 18'(in_data.m22);
    d = c0; pv = PivX;
    if (c1 > d) begin d = c1; pv = PivY; end
    if (c2 > d) begin d = c2; pv = PivZ; end
    if (c3 > d) begin d = c3; pv = PivW; end
    r = 19'(d) + 19'(1 << FracBits);
    case (pv)
      PivX: begin
        p[0] = 17'(in_data.m10) + 17'(in_data.m01);
        p[1] = 17'(in_data.m02) + 17'(in_data.m20);
        p[2] = 17'(in_data.m21) - 17'(in_data.m12);
      end
      PivY: begin
        p[0] = 17'(in_data.m10) + 17'(in_data.m01);
        p[1] = 17'(in_data.m21) + 17'(in_data.m12);
        p[2] = 17'(in_data.m02) - 17'(in_data.m20);
      end
      PivZ: begin
        p[0] = 17'(in_data.m02) + 17'(in_data.m20);
        p[1] = 17'(in_data.m21) + 17'(in_data.m12);
        p[2] = 17'(in_data.m10) - 17'(in_data.m01);
      end
      default: begin
        p[0] = 17'(in_data.m21) - 17'(in_data.m12);
        p[1] = 17'(in_data.m02) - 17'(in_data.m20);
        p[2] = 17'(in_data.m10) - 17'(in_data.m01);
      end
    endcase
    s0.pivot = pv;
    s0.bad   = (r <= 0);
    for (int k = 0; k < 3; k++) begin
      s0.neg[k] = p[k][16];
      s0.mag[k*PairW +: PairW] = p[k][16] ? PairW'(-p[k]) : PairW'(p[k]);
    end
    rad0 = s0.bad ? '0 : RootInW'({r[17:0], {(FracBits-2){1'b0}}});
  end

  logic [RootInW-1:0] rad;
  always_ff @(posedge clk) begin
    if (adv) begin
      side[0] <= s0;
      rad     <= rad0;
    end
  end
  for (genvar j = 1; j < Lat; j++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) side[j] <= side[j-1];
    end
  end
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[Lat-2:0], in_valid};
  end

  logic [RootW-1:0] root;
  rmq_sqrt u_sqrt (.clk(clk), .adv(adv), .radicand(rad), .root(root));

  logic [DenW-1:0] den;
  assign den = (root == '0) ? DenW'(1) : {root, 2'b00};
  logic [QuoW-1:0] quo [3];
  for (genvar k = 0; k < 3; k++) begin : g_div
    logic [NumW-1:0] num;
    assign num = NumW'(side[SqLat].mag[k*PairW +: PairW]) << FracBits;
    rmq_div u_div (.clk(clk), .adv(adv), .num(num), .den(den), .quo(quo[k]));
  end

  logic [RootW-1:0] rootd [DivLat+1];
  assign rootd[0] = root;
  for (genvar j = 0; j < DivLat; j++) begin : g_rd
    always_ff @(posedge clk) begin
      if (adv) rootd[j+1] <= rootd[j];
    end
  end

  side_t sl;
  logic signed [15:0] o [3];
  logic signed [15:0] cv;
  quat_t res;
  assign sl = side[Lat-1];
  always_comb begin
    cv = (rootd[DivLat] > RootW'(32767)) ? 16'sd32767 : rootd[DivLat][15:0];
    for (int k = 0; k < 3; k++) begin
      if (sl.neg[k])
        o[k] = (quo[k] >= QuoW'(32768)) ? -16'sd32768 : -$signed(quo[k][15:0]);
      else
        o[k] = (quo[k] >= QuoW'(32767)) ? 16'sd32767 : quo[k][15:0];
    end
    res.pivot = sl.pivot;
    res.invalid = sl.bad;
    case (sl.pivot)
      PivX: begin res.qx = cv; res.qy = o[0]; res.qz = o[1]; res.qw = o[2]; end
      PivY: begin res.qx = o[0]; res.qy = cv; res.qz = o[1]; res.qw = o[2]; end
      PivZ: begin res.qx = o[0]; res.qy = o[1]; res.qz = cv; res.qw = o[2]; end
      default: begin res.qx = o[0]; res.qy = o[1]; res.qz = o[2]; res.qw = cv; end
    endcase
    if (sl.bad) begin
      res.qx = '0; res.qy = '0; res.qz = '0; res.qw = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= vld[Lat-1];
  end
  always_ff @(posedge clk) begin
    if (adv) out_data <= res;
  end
endmodule
`default_nettype wire

[rtl/rmq_checker.sv]
// ---------------------------------------------------------------------------
// rmq_checker
// Port-level checks for the matrix-to-quaternion block.
// ---------------------------------------------------------------------------
`default_nettype none
`include "rotation_matrix_to_quaternion_macros.svh"
module rmq_checker
  import rmq_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  input wire logic  in_valid,
  input wire logic  in_stall,
  input wire mat_t  in_data,
  input wire logic  out_valid,
  input wire logic  out_stall,
  input wire quat_t out_data
);
  `RMQ_ASSERT_IMP(a_inv_zero, clk, rst, out_valid && out_data.invalid, out_data.qx == 0 && out_data.qy == 0 && out_data.qz == 0 && out_data.qw == 0)
  `RMQ_ASSERT_IMP(a_stall_link, clk, rst, in_stall, out_valid && out_stall)
  `RMQ_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data))
  `RMQ_ASSERT_IMP(a_w_pos, clk, rst, out_valid && !out_data.invalid && out_data.pivot == PivW, !out_data.qw[15])
  `RMQ_ASSERT_NXT(a_in_hold, clk, rst, in_valid && in_stall, in_valid && $stable(in_data))
endmodule

bind rotation_matrix_to_quaternion rmq_checker u_rmq_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
`default_nettype wire

[bench/rotation_matrix_to_quaternion_tb.sv]
// ---------------------------------------------------------------------------
// rotation_matrix_to_quaternion_tb
// Streams rotation matrices through the converter, first a short table of
// directed rows, then random and near-rotation matrices. Every quaternion is
// compared in order against its table entry or a local fixed-point model, while
// the sender idles and the receiver stalls at several rates, including one long hold-off.
// ---------------------------------------------------------------------------
`default_nettype none
module rotation_matrix_to_quaternion_tb;
  import rmq_pkg::*;

  localparam logic signed [15:0] One = 16'sd16384;

  typedef struct {
    mat_t  m;
    bit    typed;
    quat_t q;
  } row_t;

  logic  clk;
  logic  rst;
  logic  in_valid;
  logic  in_stall;
  mat_t  in_data;
  logic  out_valid;
  logic  out_stall = 1'b0;
  quat_t out_data;

  quat_t pending_quats[$];
  bit    next_typed;
  quat_t next_quat;
  int    idle_pct;
  int    stall_pct;
  bit    hold_start = 1'b0;
  bit    hold_done = 1'b0;
  int    hold_cycles = 0;
  int    errors = 0;
  int    requests = 0;
  int    results = 0;
  int    pivot_seen[4] = '{0, 0, 0, 0};

  rotation_matrix_to_quaternion u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  function automatic longint root_floor(longint n);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 <<< 62;
    while (b > n) b = b >>> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - res - b;
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] ratio(longint p, longint den);
    longint mag;
    longint q;
    mag = (p < 0) ? -p : p;
    q = ((mag <<< FracBits) + (den >>> 1)) / den;
    if (q > 65536) q = 65536;
    return clip16((p < 0) ? -q : q);
  endfunction

  function automatic quat_t convert(mat_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint d, t, r, c, den;
    logic [1:0] piv;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    q = '0;
    piv = PivX;
    d = a00 - a11 - a22;
    t = a11 - a00 - a22;
    if (t > d) begin piv = PivY; d = t; end
    t = a22 - a00 - a11;
    if (t > d) begin piv = PivZ; d = t; end
    t = a00 + a11 + a22;
    if (t > d) begin piv = PivW; d = t; end
    r = d + (64'sd1 <<< FracBits);
    q.pivot = piv;
    q.invalid = (r <= 0);
    if (r > 0) begin
      c = root_floor(r <<< (FracBits - 2));
      den = 4 * c;
      case (piv)
        PivX: begin
          q.qx = clip16(c);
          q.qy = ratio(a10 + a01, den);
          q.qz = ratio(a02 + a20, den);
          q.qw = ratio(a21 - a12, den);
        end
        PivY: begin
          q.qx = ratio(a10 + a01, den);
          q.qy = clip16(c);
          q.qz = ratio(a21 + a12, den);
          q.qw = ratio(a02 - a20, den);
        end
        PivZ: begin
          q.qx = ratio(a02 + a20, den);
          q.qy = ratio(a21 + a12, den);
          q.qz = clip16(c);
          q.qw = ratio(a10 - a01, den);
        end
        default: begin
          q.qx = ratio(a21 - a12, den);
          q.qy = ratio(a02 - a20, den);
          q.qz = ratio(a10 - a01, den);
          q.qw = clip16(c);
        end
      endcase
    end
    return q;
  endfunction

  function automatic mat_t diag(logic signed [15:0] a, logic signed [15:0] b,
                                logic signed [15:0] c);
    mat_t m;
    m = '0;
    m.m00 = a; m.m11 = b; m.m22 = c;
    return m;
  endfunction

  function automatic quat_t unit_quat(logic [1:0] piv, logic signed [15:0] v);
    quat_t q;
    q = '0;
    q.pivot = piv;
    case (piv)
      PivX: q.qx = v;
      PivY: q.qy = v;
      PivZ: q.qz = v;
      default: q.qw = v;
    endcase
    return q;
  endfunction

  function automatic logic signed [15:0] rand16(int span);
    if (span >= 32768) return 16'($urandom);
    return 16'($urandom_range(2 * span) - span);
  endfunction

  function automatic mat_t random_mat();
    mat_t m;
    int k;
    k = $urandom_range(9);
    m = mat_t'(144'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    if (k < 6) begin
      // near-rotation: dominant diagonal sign pattern, modest off-diagonals
      m.m01 = rand16(6000); m.m02 = rand16(6000); m.m10 = rand16(6000);
      m.m12 = rand16(6000); m.m20 = rand16(6000); m.m21 = rand16(6000);
      m.m00 = rand16(16384); m.m11 = rand16(16384); m.m22 = rand16(16384);
    end else if (k < 8) begin
      m.m00 = rand16(2000); m.m11 = rand16(2000); m.m22 = rand16(2000);
    end
    return m;
  endfunction

  task automatic send(mat_t m, bit typed, quat_t q);
    next_typed <= typed;
    next_quat <= q;
    in_data <= m;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    while (pending_quats.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Test completed with failures");
    $finish;
  end

  always @(posedge clk) begin
    if (hold_start && !hold_done) begin
      hold_done <= 1'b1;
      hold_cycles <= 200;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    quat_t want;
    if (!rst && in_valid && !in_stall) begin
      pending_quats.push_back(next_typed ? next_quat : convert(in_data));
      requests <= requests + 1;
    end
    if (!rst && out_valid && !out_stall) begin
      results <= results + 1;
      pivot_seen[out_data.pivot] <= pivot_seen[out_data.pivot] + 1;
      if (pending_quats.size() == 0) begin
        errors <= errors + 1;
        $display("%0t: unexpected quaternion, actual %h", $realtime, out_data);
      end else begin
        want = pending_quats.pop_front();
        if (out_data !== want) begin
          errors <= errors + 1;
          $display("%0t: mismatch, expected qx %0d qy %0d qz %0d qw %0d piv %0d inv %0d",
                   $realtime, want.qx, want.qy, want.qz, want.qw, want.pivot,
                   want.invalid);
          $display("%0t:          actual   qx %0d qy %0d qz %0d qw %0d piv %0d inv %0d",
                   $realtime, out_data.qx, out_data.qy, out_data.qz, out_data.qw,
                   out_data.pivot, out_data.invalid);
        end
      end
    end
  end

  initial begin
    row_t rows[$];
    row_t rw;
    mat_t m;
    int ph;
    int pct_idle[4];
    int pct_stall[4];
    pct_idle  = '{0, 66, 0, 38};
    pct_stall = '{0, 0, 66, 38};
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    next_typed = 1'b0;
    next_quat = '0;
    idle_pct = 0;
    stall_pct = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    rows.push_back('{diag(16'sd0, 16'sd0, 16'sd0), 1, unit_quat(PivX, 16'sd8192)});
    rows.push_back('{diag(One, -One, -One), 1, unit_quat(PivX, 16'sd16384)});
    rows.push_back('{diag(-One, One, -One), 1, unit_quat(PivY, 16'sd16384)});
    rows.push_back('{diag(-One, -One, One), 1, unit_quat(PivZ, 16'sd16384)});
    rows.push_back('{diag(One, One, One), 1, unit_quat(PivW, 16'sd16384)});
    rows.push_back('{mat_t'({9{16'sh7fff}}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({9{16'sh8000}}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                             16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                             16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000,
                             16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                             16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0,
                             16'sd0, 16'sd0, 16'sd0, 16'sd16384}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sd11585, -16'sd11585, 16'sd0, 16'sd11585, 16'sd11585,
                             16'sd0, 16'sd0, 16'sd0, 16'sd16384}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'sd1, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sd0,
                             16'sh7fff, 16'sh7fff, 16'sh8000, -16'sd1}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff,
                             16'hffff, 16'hffff, 16'hffff, 16'hffff}), 0, quat_t'('0)});
    rows.push_back('{mat_t'({16'h5555, 16'haaaa, 16'h5555, 16'haaaa, 16'h5555,
                             16'haaaa, 16'h5555, 16'haaaa, 16'h5555}), 0, quat_t'('0)});
    foreach (rows[i]) begin
      rw = rows[i];
      send(rw.m, rw.typed, rw.q);
    end
    in_valid <= 1'b0;
    drain();

    for (ph = 0; ph < 4; ph++) begin
      idle_pct = pct_idle[ph];
      stall_pct = pct_stall[ph];
      for (int n = 0; n < 110; n++) begin
        if (ph == 0 && n == 20) hold_start <= 1'b1;
        m = random_mat();
        send(m, 1'b0, quat_t'('0));
      end
      in_valid <= 1'b0;
      if (ph < 3) begin
        repeat ($urandom_range(20)) @(posedge clk);
      end
    end
    drain();

    $display("Converted %0d matrices, %0d quaternions checked; pivots x %0d y %0d z %0d w %0d",
             requests, results, pivot_seen[0], pivot_seen[1], pivot_seen[2],
             pivot_seen[3]);
    $display("Idle/stall mixes: none, sender idle, receiver stall, both; one long hold-off");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
`default_nettype wire
